FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the checker files of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define URPD_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define URPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/urpd_pkg.sv
// Shared constants and types of the UART receiver with PWM duty output.
package urpd_pkg;

  localparam int DataBits   = 8;
  localparam int TickWidth  = 16;
  localparam int IdxW       = $clog2(DataBits + 1);
  localparam int PosW       = $clog2(DataBits);
  localparam int CfgW       = 16;
  localparam int DutyW      = 7;
  localparam int ByteW      = 8;

  localparam logic [DutyW-1:0] DutyMax = DutyW'(100);

  // duty * period / 100 is done as period * (duty * ceil(2^30 / 100)) >> 30,
  // which is exact for every duty up to 100 and every 16-bit period.
  localparam int            ScaleShift = 30;
  localparam int            RecipW     = 24;
  localparam logic [RecipW-1:0] ScaleRecip = RecipW'(((64'd1 << ScaleShift) + 64'd99) / 64'd100);
  localparam int            ScaleW     = DutyW + RecipW;

  // Configuration register indexes.
  localparam logic [1:0] CfgHalfBit = 2'd0;
  localparam logic [1:0] CfgBit     = 2'd1;
  localparam logic [1:0] CfgPeriod  = 2'd2;

  typedef struct packed {
    logic             done;
    logic             err;
    logic [ByteW-1:0] value;
  } rx_result_t;

  typedef struct packed {
    logic             valid;
    logic [DutyW-1:0] pct;
  } duty_upd_t;

endpackage

FILE: rtl/core/urpd_rx.sv
// Serial frame receiver: start edge detect, half-bit realignment, bit sampling, stop-bit check.
module urpd_rx (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              step_i,
  input  logic                              rx_i,
  input  logic [urpd_pkg::CfgW-1:0]         half_bit_ticks_i,
  input  logic [urpd_pkg::CfgW-1:0]         bit_ticks_i,
  output urpd_pkg::rx_result_t              res_o,
  output urpd_pkg::duty_upd_t               duty_o
);

  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhHalf = 2'd1;
  localparam logic [1:0] PhBits = 2'd2;

  logic [1:0]                         phase_q, phase_d;
  logic                               prev_q, prev_d;
  logic [urpd_pkg::TickWidth-1:0]     tick_q, tick_d;
  logic [urpd_pkg::IdxW-1:0]          idx_q, idx_d;
  logic [urpd_pkg::ByteW-1:0]         shift_q, shift_d;
  logic [urpd_pkg::TickWidth-1:0]     tick_inc;
  logic [urpd_pkg::TickWidth-1:0]     half_lim;
  logic [urpd_pkg::TickWidth-1:0]     bit_lim;
  logic [urpd_pkg::ByteW-1:0]         rx_bit;

  assign tick_inc = tick_q + urpd_pkg::TickWidth'(1);
  assign half_lim = (half_bit_ticks_i == '0) ? urpd_pkg::TickWidth'(1)
                                             : urpd_pkg::TickWidth'(half_bit_ticks_i);
  assign bit_lim  = (bit_ticks_i == '0) ? urpd_pkg::TickWidth'(1)
                                        : urpd_pkg::TickWidth'(bit_ticks_i);
  assign rx_bit   = urpd_pkg::ByteW'(rx_i) << idx_q[urpd_pkg::PosW-1:0];

  always_comb begin
    phase_d   = phase_q;
    tick_d    = tick_q;
    idx_d     = idx_q;
    shift_d   = shift_q;
    prev_d    = rx_i;
    res_o     = '0;
    duty_o    = '0;
    unique case (phase_q)
      PhIdle: begin
        if (prev_q && !rx_i) begin
          phase_d = PhHalf;
          tick_d  = '0;
          idx_d   = '0;
          shift_d = '0;
        end
      end
      PhHalf: begin
        tick_d = tick_inc;
        if (tick_inc >= half_lim) begin
          phase_d = PhBits;
          tick_d  = '0;
        end
      end
      PhBits: begin
        tick_d = tick_inc;
        if (tick_inc >= bit_lim) begin
          tick_d = '0;
          if (idx_q < urpd_pkg::IdxW'(urpd_pkg::DataBits)) begin
            shift_d = shift_q | rx_bit;
            idx_d   = idx_q + urpd_pkg::IdxW'(1);
          end else begin
            if (rx_i) begin
              res_o.done   = 1'b1;
              res_o.value  = shift_q;
              duty_o.valid = 1'b1;
              duty_o.pct   = (shift_q > urpd_pkg::ByteW'(urpd_pkg::DutyMax))
                             ? urpd_pkg::DutyMax : urpd_pkg::DutyW'(shift_q);
            end else begin
              res_o.err = 1'b1;
            end
            phase_d = PhIdle;
            idx_d   = '0;
          end
        end
      end
      default: begin
        phase_d = PhIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      prev_q  <= 1'b1;
      tick_q  <= '0;
      idx_q   <= '0;
      shift_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      prev_q  <= prev_d;
      tick_q  <= tick_d;
      idx_q   <= idx_d;
      shift_q <= shift_d;
    end
  end

endmodule

FILE: rtl/core/urpd_pwm.sv
// PWM generator: period counter, on-time latch and scaled duty register.
module urpd_pwm (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [urpd_pkg::CfgW-1:0]  period_ticks_i,
  input  urpd_pkg::duty_upd_t        duty_i,
  output logic                       level_o
);

  localparam int CntW  = urpd_pkg::CfgW;
  localparam int ProdW = CntW + urpd_pkg::ScaleW;

  logic [urpd_pkg::ScaleW-1:0] scale_q, scale_d;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic [CntW-1:0]             on_q, on_d;
  logic [CntW-1:0]             period;
  logic [ProdW-1:0]            prod;
  logic [CntW-1:0]             on_calc;
  logic [CntW-1:0]             cnt_inc;

  assign period  = (period_ticks_i == '0) ? CntW'(1) : period_ticks_i;
  // Duty is held pre-multiplied by the reciprocal of 100, so the on-time
  // needs only one multiply by the period here.
  assign prod    = ProdW'(period) * ProdW'(scale_q);
  assign on_calc = prod[urpd_pkg::ScaleShift +: CntW];
  assign on_d    = (cnt_q == '0) ? on_calc : on_q;
  assign level_o = (cnt_q < on_d);
  assign cnt_inc = cnt_q + CntW'(1);
  assign cnt_d   = (cnt_inc >= period) ? '0 : cnt_inc;
  assign scale_d = duty_i.valid
                   ? urpd_pkg::ScaleW'(duty_i.pct) * urpd_pkg::ScaleW'(urpd_pkg::ScaleRecip)
                   : scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= '0;
      cnt_q   <= '0;
      on_q    <= '0;
    end else if (step_i) begin
      scale_q <= scale_d;
      cnt_q   <= cnt_d;
      on_q    <= on_d;
    end
  end

endmodule

FILE: rtl/core/uart_rx_pwm_duty_controller.sv
// Top level of the UART 8N1 receiver that sets the duty of a PWM output.
//
// Usage: every input word on the in channel (in_valid_i / in_ready_o) is one
// sample tick of the serial receive line, rx_level_i, idle high. For every
// accepted word the block returns exactly one output word on the out channel
// (out_valid_o / out_ready_i) carrying the PWM pin level for that tick, a
// byte_done flag with the received byte, and a frame_error flag. A received
// byte becomes the PWM duty in percent, saturated at 100, from the next period.
// A word is held in the input register and is then processed into the output
// register, from which its result is shown. Throughput is one word per cycle
// while the out channel does not stall, set by one pass through the receiver
// and PWM logic, whose longest path is the on-time multiply.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i at once
// (0 half-bit ticks, 1 bit ticks, 2 PWM period ticks); an unused index is
// ignored. A register written as zero behaves as one.
// Reset restores the register defaults (48, 97, 300), idles the receiver,
// zeroes the duty and empties both pipeline registers. When the out channel
// stalls, the result holds, the input register takes one more word and then
// in_ready_o drops, so no word is lost or repeated.
module uart_rx_pwm_duty_controller (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             rx_level_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             pwm_level_o,
  output logic                             byte_done_o,
  output logic [urpd_pkg::ByteW-1:0]       byte_value_o,
  output logic                             frame_error_o,
  input  logic                             cfg_we_i,
  input  logic [1:0]                       cfg_idx_i,
  input  logic [urpd_pkg::CfgW-1:0]        cfg_data_i
);

  // Configuration registers.
  logic [urpd_pkg::CfgW-1:0] half_q, bit_q, period_q;

  // Input register stage.
  logic s1_valid_q, s1_valid_d;
  logic s1_rx_q;
  logic advance;

  // Output register stage.
  logic                        out_valid_q, out_valid_d;
  logic                        pwm_q;
  urpd_pkg::rx_result_t        res_q;

  urpd_pkg::rx_result_t        rx_res;
  urpd_pkg::duty_upd_t         duty_upd;
  logic                        pwm_level;

  // The tick held in the input register is processed when the output
  // register is empty or being drained in this cycle.
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  assign s1_valid_d  = (in_valid_i && in_ready_o) ? 1'b1 : (advance ? 1'b0 : s1_valid_q);
  assign out_valid_d = advance ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q   <= urpd_pkg::CfgW'(48);
      bit_q    <= urpd_pkg::CfgW'(97);
      period_q <= urpd_pkg::CfgW'(300);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        urpd_pkg::CfgHalfBit: half_q   <= cfg_data_i;
        urpd_pkg::CfgBit:     bit_q    <= cfg_data_i;
        urpd_pkg::CfgPeriod:  period_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_rx_q <= rx_level_i;
    end
    if (advance) begin
      pwm_q <= pwm_level;
      res_q <= rx_res;
    end
  end

  urpd_rx u_rx (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (advance),
    .rx_i             (s1_rx_q),
    .half_bit_ticks_i (half_q),
    .bit_ticks_i      (bit_q),
    .res_o            (rx_res),
    .duty_o           (duty_upd)
  );

  urpd_pwm u_pwm (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .period_ticks_i (period_q),
    .duty_i         (duty_upd),
    .level_o        (pwm_level)
  );

  assign out_valid_o   = out_valid_q;
  assign pwm_level_o   = pwm_q;
  assign byte_done_o   = res_q.done;
  assign byte_value_o  = res_q.value;
  assign frame_error_o = res_q.err;

endmodule

FILE: rtl/core/urpd_checker.sv
// Port-level checker for the UART receiver with PWM duty output, with its bind.
`include "assert_macros.svh"

module urpd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic                        byte_done_o,
  input logic [urpd_pkg::ByteW-1:0]  byte_value_o,
  input logic                        frame_error_o
);

  // A frame ends either good or bad, never both.
  `URPD_ASSERT(a_done_xor_err, out_valid_o, !(byte_done_o && frame_error_o), "done and error together")

  // The byte field reads zero on ticks that end no good frame.
  `URPD_ASSERT(a_value_zero, out_valid_o && !byte_done_o, byte_value_o == '0, "byte without done")

  // With the output register empty the input side must take a word.
  `URPD_ASSERT(a_ready_when_empty, !out_valid_o, in_ready_o, "input blocked while output empty")

  // A finished frame leaves the receiver idle, so the next tick ends none.
  `URPD_ASSERT_NEXT(a_no_double_done, out_valid_o && out_ready_i && byte_done_o,
                    !(out_valid_o && byte_done_o), "two frames on consecutive ticks")

  // A result is held until it is taken.
  `URPD_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped")

endmodule

bind uart_rx_pwm_duty_controller urpd_checker u_urpd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .byte_done_o   (byte_done_o),
  .byte_value_o  (byte_value_o),
  .frame_error_o (frame_error_o)
);

FILE: dv/tb_uart_rx_pwm_duty_controller.sv
// Self-checking testbench for the UART receiver that sets the duty of a PWM output.
`timescale 1ns / 1ps

module tb_uart_rx_pwm_duty_controller;

  // Run shape. Random phases each pick a fresh register setting and then stream
  // mostly well-formed serial frames with random bytes, mixed with line noise.
  localparam int unsigned NumPhases      = 8;
  localparam int unsigned WordsPerPhase  = 90;
  localparam int unsigned LongHoldCycles = 400;
  localparam int unsigned DrainCycles    = 8;
  localparam int unsigned CycleLimit     = 600_000;
  localparam int unsigned MaxPrinted     = 40;

  // Index with no register behind it; a write there must change nothing.
  localparam logic [1:0] CfgUnused = 2'd3;

  // Receiver phases of the predictor.
  typedef enum logic [1:0] {RxIdle, RxHalf, RxBits} rx_phase_e;

  // Fields of one result word.
  typedef struct packed {
    logic                       pwm;
    logic                       done;
    logic [urpd_pkg::ByteW-1:0] value;
    logic                       err;
  } tick_result_t;

  // A word on its way in, with an optional hand-written expectation.
  typedef struct {
    bit           typed;
    tick_result_t want;
  } typed_word_t;

  typedef enum logic [1:0] {RowLevel, RowCfg, RowFrame} row_kind_e;

  // One row of the directed table. For a level row, count is the number of
  // words; for a frame row, it is the bit length in words and lvl is the stop
  // level; data holds the register value or the frame byte.
  typedef struct packed {
    row_kind_e    kind;
    logic         lvl;
    logic [15:0]  count;
    logic [1:0]   idx;
    logic [15:0]  data;
    logic         has_exp;
    tick_result_t want;
  } dir_row_t;

  localparam tick_result_t ResLow  = '{1'b0, 1'b0, 8'h00, 1'b0};
  localparam tick_result_t ResHigh = '{1'b1, 1'b0, 8'h00, 1'b0};

  localparam int NumDirRows = 27;

  // The directed part. The receiver starts with the reset registers (48, 97,
  // 300), so the first edge parks it in a long half-bit wait until the
  // registers are rewritten underneath it.
  localparam dir_row_t DirRows [NumDirRows] = '{
    // After reset the duty is zero: the pin is low and nothing is received.
    '{RowLevel, 1'b1, 16'd4,  urpd_pkg::CfgHalfBit, 16'h0000, 1'b1, ResLow},
    // Falling edge: the frame starts, still nothing to report.
    '{RowLevel, 1'b0, 16'd1,  urpd_pkg::CfgHalfBit, 16'h0000, 1'b1, ResLow},
    // Registers written as zero act as one; the half-bit write lands mid-frame.
    '{RowCfg,   1'b0, 16'd0,  urpd_pkg::CfgHalfBit, 16'h0000, 1'b0, ResLow},
    '{RowCfg,   1'b0, 16'd0,  urpd_pkg::CfgBit,     16'h0000, 1'b0, ResLow},
    '{RowCfg,   1'b0, 16'd0,  urpd_pkg::CfgPeriod,  16'h0000, 1'b0, ResLow},
    // Unused index with all data bits set is ignored.
    '{RowCfg,   1'b0, 16'd0,  CfgUnused,            16'hFFFF, 1'b0, ResLow},
    // All-ones byte completes; 255 saturates the duty at 100.
    '{RowLevel, 1'b1, 16'd12, urpd_pkg::CfgHalfBit, 16'h0000, 1'b0, ResLow},
    // With a one-tick period and full duty the pin is high on every tick.
    '{RowLevel, 1'b1, 16'd3,  urpd_pkg::CfgHalfBit, 16'h0000, 1'b1, ResHigh},
    '{RowCfg,   1'b0, 16'd0,  urpd_pkg::CfgHalfBit, 16'h0001, 1'b0, ResLow},
    '{RowCfg,   1'b0, 16'd0,  urpd_pkg::CfgBit,     16'h0002, 1'b0, ResLow},
    // Longest period: the on-time latched at its start covers all of it.
    '{RowCfg,   1'b0, 16'd0,  urpd_pkg::CfgPeriod,  16'hFFFF, 1'b0, ResLow},
    '{RowFrame, 1'b1, 16'd2,  urpd_pkg::CfgHalfBit, 16'h0032, 1'b0, ResLow},
    // Period shrunk mid-period: the counter wraps at once, pin high until then.
    '{RowCfg,   1'b0, 16'd0,  urpd_pkg::CfgPeriod,  16'h0007, 1'b0, ResLow},
    // Low stop bit: framing error, the duty is kept.
    '{RowFrame, 1'b0, 16'd2,  urpd_pkg::CfgHalfBit, 16'h0000, 1'b0, ResLow},
    '{RowLevel, 1'b1, 16'd2,  urpd_pkg::CfgHalfBit, 16'h0000, 1'b0, ResLow},
    // Duty of one percent truncates to no on-time at all.
    '{RowFrame, 1'b1, 16'd2,  urpd_pkg::CfgHalfBit, 16'h0001, 1'b0, ResLow},
    // Just above the limit: saturates to 100.
    '{RowFrame, 1'b1, 16'd2,  urpd_pkg::CfgHalfBit, 16'h0065, 1'b0, ResLow},
    // A one-tick start pulse is enough; the start bit is never checked.
    '{RowLevel, 1'b0, 16'd1,  urpd_pkg::CfgHalfBit, 16'h0000, 1'b0, ResLow},
    '{RowLevel, 1'b1, 16'd20, urpd_pkg::CfgHalfBit, 16'h0000, 1'b0, ResLow},
    // Alternating data puts falling edges inside the frame.
    '{RowFrame, 1'b1, 16'd2,  urpd_pkg::CfgHalfBit, 16'h0055, 1'b0, ResLow},
    '{RowFrame, 1'b1, 16'd2,  urpd_pkg::CfgHalfBit, 16'h0000, 1'b0, ResLow},
    // Longest half-bit and bit times, then shortened while a frame is open.
    '{RowCfg,   1'b0, 16'd0,  urpd_pkg::CfgHalfBit, 16'hFFFF, 1'b0, ResLow},
    '{RowCfg,   1'b0, 16'd0,  urpd_pkg::CfgBit,     16'hFFFF, 1'b0, ResLow},
    '{RowLevel, 1'b0, 16'd6,  urpd_pkg::CfgHalfBit, 16'h0000, 1'b0, ResLow},
    '{RowCfg,   1'b0, 16'd0,  urpd_pkg::CfgHalfBit, 16'h0001, 1'b0, ResLow},
    '{RowCfg,   1'b0, 16'd0,  urpd_pkg::CfgBit,     16'h0001, 1'b0, ResLow},
    '{RowLevel, 1'b1, 16'd12, urpd_pkg::CfgHalfBit, 16'h0000, 1'b0, ResLow}
  };

  // Block ports; every input has a known value from time zero.
  logic                       clk_i        = 1'b0;
  logic                       rst_ni       = 1'b0;
  logic                       in_valid_i   = 1'b0;
  logic                       in_ready_o;
  logic                       rx_level_i   = 1'b1;
  logic                       out_valid_o;
  logic                       out_ready_i  = 1'b0;
  logic                       pwm_level_o;
  logic                       byte_done_o;
  logic [urpd_pkg::ByteW-1:0] byte_value_o;
  logic                       frame_error_o;
  logic                       cfg_we_i     = 1'b0;
  logic [1:0]                 cfg_idx_i    = 2'd0;
  logic [urpd_pkg::CfgW-1:0]  cfg_data_i   = '0;

  // Predictor state, starting at the reset values of the block.
  logic [15:0]                half_cfg   = 16'd48;
  logic [15:0]                bit_cfg    = 16'd97;
  logic [15:0]                period_cfg = 16'd300;
  rx_phase_e                  rx_state   = RxIdle;
  logic                       line_prev  = 1'b1;
  logic [15:0]                tick_cnt   = '0;
  logic [3:0]                 bit_cnt    = '0;
  logic [urpd_pkg::ByteW-1:0] shift_reg  = '0;
  logic [urpd_pkg::DutyW-1:0] duty_pct   = '0;
  logic [15:0]                on_time    = '0;
  logic [15:0]                pwm_cnt    = '0;

  tick_result_t     tick_results_q [$];
  typed_word_t      typed_q [$];
  int unsigned      words_sent    = 0;
  int unsigned      results_seen  = 0;
  int unsigned      fail_count    = 0;
  bit               no_gaps       = 1'b0;
  bit               long_hold_req = 1'b0;

  uart_rx_pwm_duty_controller uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_level_i    (rx_level_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pwm_level_o   (pwm_level_o),
    .byte_done_o   (byte_done_o),
    .byte_value_o  (byte_value_o),
    .frame_error_o (frame_error_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs a handshake.
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("FAIL");
    $finish;
  end

  function automatic logic [15:0] min_one(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  // Advances the predictor by one tick of the line and returns what the block
  // should show for it. The PWM level comes first, from the on-time latched at
  // the last period start, so a duty stored on this tick only counts from the
  // next period on.
  function automatic tick_result_t rx_pwm_tick(input logic lvl);
    tick_result_t res;
    logic [15:0]  period;
    logic [31:0]  on_prod;
    res = '0;
    period = min_one(period_cfg);
    if (pwm_cnt == 16'd0) begin
      on_prod = 32'(duty_pct) * 32'(period) / 32'(urpd_pkg::DutyMax);
      on_time = on_prod[15:0];
    end
    res.pwm = (pwm_cnt < on_time);
    pwm_cnt = pwm_cnt + 16'd1;
    // Covers a period that shrank below the running count as well.
    if (pwm_cnt >= period) pwm_cnt = '0;

    case (rx_state)
      RxIdle: begin
        if (line_prev && !lvl) begin
          rx_state  = RxHalf;
          tick_cnt  = '0;
          bit_cnt   = '0;
          shift_reg = '0;
        end
      end
      RxHalf: begin
        tick_cnt = tick_cnt + 16'd1;
        if (tick_cnt >= min_one(half_cfg)) begin
          rx_state = RxBits;
          tick_cnt = '0;
        end
      end
      default: begin
        tick_cnt = tick_cnt + 16'd1;
        if (tick_cnt >= min_one(bit_cfg)) begin
          tick_cnt = '0;
          if (bit_cnt < 4'(urpd_pkg::DataBits)) begin
            shift_reg[bit_cnt[2:0]] = shift_reg[bit_cnt[2:0]] | lvl;
            bit_cnt = bit_cnt + 4'd1;
          end else begin
            if (lvl) begin
              res.done  = 1'b1;
              res.value = shift_reg;
              duty_pct  = (shift_reg > urpd_pkg::ByteW'(urpd_pkg::DutyMax))
                          ? urpd_pkg::DutyMax : shift_reg[urpd_pkg::DutyW-1:0];
            end else begin
              res.err = 1'b1;
            end
            rx_state = RxIdle;
            bit_cnt  = '0;
          end
        end
      end
    endcase
    line_prev = lvl;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (fail_count < MaxPrinted)
      $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  // Checks every result word against the oldest expectation, then runs the
  // predictor on every word taken in and applies register writes. All of this
  // looks at values from before the edge, so it does not race the drivers.
  always @(posedge clk_i) begin : tick_monitor
    tick_result_t got;
    tick_result_t want;
    tick_result_t predicted;
    typed_word_t  tag;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        got = '{pwm_level_o, byte_done_o, byte_value_o, frame_error_o};
        if (tick_results_q.size() == 0) begin
          report_mismatch("result word with nothing expected", got, 0);
        end else begin
          want = tick_results_q.pop_front();
          if (got.pwm != want.pwm)     report_mismatch("pwm_level", got.pwm, want.pwm);
          if (got.done != want.done)   report_mismatch("byte_done", got.done, want.done);
          if (got.value != want.value) report_mismatch("byte_value", got.value, want.value);
          if (got.err != want.err)     report_mismatch("frame_error", got.err, want.err);
        end
      end
      if (in_valid_i && in_ready_o) begin
        predicted = rx_pwm_tick(rx_level_i);
        tag = typed_q.pop_front();
        // A hand-written expectation replaces the predicted one for its word.
        tick_results_q.push_back(tag.typed ? tag.want : predicted);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          urpd_pkg::CfgHalfBit: half_cfg   = cfg_data_i;
          urpd_pkg::CfgBit:     bit_cfg    = cfg_data_i;
          urpd_pkg::CfgPeriod:  period_cfg = cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Idle length for either side: mostly none or short, now and then long, and
  // none at all while a quiet stretch is on.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Result side: random stalls, plus one long hold-off on request so that the
  // block fills up and has to drop in_ready_o.
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk_i);
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Offers one word and holds it until it is taken.
  task automatic send_word(input logic lvl, input bit typed = 1'b0,
                           input tick_result_t want = '0);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    typed_q.push_back('{typed, want});
    in_valid_i <= 1'b1;
    rx_level_i <= lvl;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
  endtask

  // One 8N1 frame with every bit held for bit_len words.
  task automatic send_frame(input logic [urpd_pkg::ByteW-1:0] data, input logic stop_lvl,
                            input int unsigned bit_len);
    int unsigned k;
    repeat (bit_len) send_word(1'b0);
    for (k = 0; k < urpd_pkg::DataBits; k++) repeat (bit_len) send_word(data[k]);
    repeat (bit_len) send_word(stop_lvl);
  endtask

  // Stops offering words and waits until every word has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (results_seen != words_sent);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Short bit times keep frames to a few dozen words; the half-bit time is
  // usually centered on the bit and sometimes off so sampling misses.
  task automatic pick_config();
    logic [15:0] bit_len;
    logic [15:0] half_len;
    logic [15:0] period;
    case ($urandom_range(0, 9))
      0:       bit_len = 16'd0;
      1:       bit_len = 16'd1;
      2:       bit_len = 16'($urandom_range(7, 16));
      default: bit_len = 16'($urandom_range(2, 6));
    endcase
    if ($urandom_range(0, 4) != 0) half_len = bit_len >> 1;
    else half_len = 16'($urandom_range(0, bit_len + 1));
    case ($urandom_range(0, 19))
      0:                 period = 16'd0;
      1, 2, 3, 4, 5, 6:  period = 16'($urandom_range(1, 10));
      7, 8, 9:           period = 16'($urandom_range(100, 500));
      default:           period = 16'($urandom_range(10, 100));
    endcase
    write_reg(urpd_pkg::CfgBit, bit_len);
    write_reg(urpd_pkg::CfgHalfBit, half_len);
    write_reg(urpd_pkg::CfgPeriod, period);
    if ($urandom_range(0, 1) != 0) write_reg(CfgUnused, 16'($urandom));
  endtask

  // Bytes lean toward the duty range and its edges.
  function automatic logic [urpd_pkg::ByteW-1:0] pick_byte();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return urpd_pkg::ByteW'($urandom_range(0, 100));
      4: begin
        case ($urandom_range(0, 5))
          0:       return 8'd0;
          1:       return 8'd1;
          2:       return 8'd99;
          3:       return 8'd100;
          4:       return 8'd101;
          default: return 8'd255;
        endcase
      end
      default: return urpd_pkg::ByteW'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin : stimulus
    int          i;
    int unsigned phase;
    int unsigned phase_end;
    int unsigned r;
    int unsigned bit_len;
    dir_row_t    row;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < NumDirRows; i++) begin
      row = DirRows[i];
      case (row.kind)
        RowLevel: repeat (row.count) send_word(row.lvl, row.has_exp, row.want);
        RowCfg: begin
          drain();
          write_reg(row.idx, row.data);
        end
        default: send_frame(row.data[urpd_pkg::ByteW-1:0], row.lvl, row.count);
      endcase
    end

    for (phase = 0; phase < NumPhases; phase++) begin
      drain();
      pick_config();
      // Every third phase runs with neither side idling.
      no_gaps = (phase % 3 == 2);
      // The sender keeps offering words through this hold-off.
      if (phase == 1) long_hold_req = 1'b1;
      phase_end = words_sent + WordsPerPhase;
      while (words_sent < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          // Mostly matched to the bit time; sometimes one word off so the
          // sample points drift through the frame.
          bit_len = min_one(bit_cfg);
          if ($urandom_range(0, 9) == 0) bit_len = bit_len + 1;
          else if ($urandom_range(0, 9) == 0 && bit_len > 1) bit_len = bit_len - 1;
          send_frame(pick_byte(), ($urandom_range(0, 9) != 0), bit_len);
          repeat ($urandom_range(0, 3)) send_word(1'b1);
        end else if (r < 90) begin
          repeat ($urandom_range(1, 8)) send_word(1'($urandom_range(0, 1)));
        end else begin
          repeat ($urandom_range(1, 6)) send_word(1'b1);
        end
      end
    end

    no_gaps = 1'b0;
    drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (tick_results_q.size() != 0)
      report_mismatch("expected words never returned", 0, tick_results_q.size());

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/urpd_pkg.sv
rtl/core/urpd_rx.sv
rtl/core/urpd_pwm.sv
rtl/core/uart_rx_pwm_duty_controller.sv
rtl/core/urpd_checker.sv
dv/tb_uart_rx_pwm_duty_controller.sv
